// ===== design/tscd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscd_pkg
// Shared widths, calendar constants, reciprocal constants and result types
// for the timestamp to calendar date converter.
// ----------------------------------------------------------------------------
package tscd_pkg;

  // Field widths.
  localparam int unsigned SECS_W  = 38;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned SOD_W   = 17;

  // Last supported second: 9999-12-31 23:59:59.
  localparam logic [SECS_W-1:0] LAST_SECOND = 38'd253402300799;

  // Seconds per day is 675 * 2^7: the low seven bits pass straight into the
  // second of day and the rest is divided by 675.
  localparam int unsigned DAY_LOW_W = 7;
  localparam int unsigned DAY_ODD   = 675;
  localparam int unsigned T_W       = SECS_W - DAY_LOW_W;
  localparam int unsigned DAYS_W    = 22;
  localparam int unsigned RECIP675_W = 22;
  localparam logic [RECIP675_W-1:0] RECIP675 = 22'((64'd1 << T_W) / DAY_ODD);

  // Day counts of the Gregorian cycles.
  localparam int unsigned DAYS_0001_TO_1970 = 719162;
  localparam int unsigned DAYS_400Y = 146097;
  localparam int unsigned DAYS_100Y = 36524;
  localparam int unsigned DAYS_4Y   = 1461;
  localparam int unsigned DAYS_1Y   = 365;

  // Floor reciprocals; the shift equals the dividend width, so the estimate
  // is never high and at most one below the true quotient.
  localparam logic [4:0]  RECIP400  = 5'((64'd1 << DAYS_W) / DAYS_400Y);
  localparam logic [5:0]  RECIP1461 = 6'((64'd1 << 16) / DAYS_4Y);
  localparam int unsigned SECS_MIN  = 60;
  localparam logic [11:0] RECIP60   = 12'((64'd1 << SOD_W) / SECS_MIN);

  // Pipeline depths.
  localparam int unsigned FRONT_STAGES  = 4;
  localparam int unsigned DATE_LAT      = 11;
  localparam int unsigned TIME_CORE_LAT = 6;
  localparam int unsigned TIME_PAD      = DATE_LAT - TIME_CORE_LAT;
  localparam int unsigned PIPE_DEPTH    = FRONT_STAGES + DATE_LAT;

  // Time of day result.
  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic [SOD_W-1:0]  sod;
  } tscd_time_t;

  // Calendar date result.
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               oor;
  } tscd_date_t;

  // Days in the year before the first day of month m.
  function automatic logic [8:0] tscd_dbm(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    base = 9'd0;
    case (m)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (m > 4'd2 && leap) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

// ===== design/tscd_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscd_in_if
// Input channel: one Unix timestamp per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tscd_in_if;
  logic                        valid;
  logic                        ready;
  logic [tscd_pkg::SECS_W-1:0] unix_seconds;

  modport source (output valid, output unix_seconds, input ready);
  modport sink (input valid, input unix_seconds, output ready);
endinterface

// ===== design/tscd_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscd_out_if
// Result channel: one calendar date and time of day per item.
// ----------------------------------------------------------------------------
interface tscd_out_if;
  logic                         valid;
  logic                         ready;
  logic [tscd_pkg::YEAR_W-1:0]  year;
  logic [tscd_pkg::MONTH_W-1:0] month;
  logic [tscd_pkg::DAY_W-1:0]   day_of_month;
  logic [tscd_pkg::HOUR_W-1:0]  hour;
  logic [tscd_pkg::MIN_W-1:0]   minute;
  logic [tscd_pkg::SEC_W-1:0]   second;
  logic [tscd_pkg::SOD_W-1:0]   second_of_day;
  logic                         out_of_range;

  modport source (output valid, output year, output month, output day_of_month,
                  output hour, output minute, output second, output second_of_day,
                  output out_of_range, input ready);
  modport sink (input valid, input year, input month, input day_of_month,
                input hour, input minute, input second, input second_of_day,
                input out_of_range, output ready);
endinterface

// ===== design/tscd_time.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscd_time
// Splits the second of day into hour, minute and second through two
// reciprocal divisions by 60, then delays the result to match the date path.
// ----------------------------------------------------------------------------
module tscd_time (
  input  logic                        clk,
  input  logic                        adv,
  input  logic [tscd_pkg::SOD_W-1:0]  sod,
  output tscd_pkg::tscd_time_t        tm
);
  import tscd_pkg::*;

  logic [28:0]      p1_nxt, p1_r;
  logic [SOD_W-1:0] sod1_r, sod2_r, sod3_r, sod4_r, sod5_r;
  logic [11:0]      m0_w;
  logic [10:0]      min2_nxt, min2_r;
  logic [6:0]       s2_nxt, s2_r;
  logic [10:0]      min3_nxt, min3_r, min4_r;
  logic [SEC_W-1:0] sec3_nxt, sec3_r, sec4_r, sec5_r;
  logic [22:0]      p4_nxt, p4_r;
  logic [5:0]       h0_w;
  logic [HOUR_W-1:0] hr5_nxt, hr5_r;
  logic [6:0]       mi5_nxt, mi5_r;
  tscd_time_t       tm6_nxt, tm6_r;
  tscd_time_t       pad_r [TIME_PAD];

  always_comb begin
    // Minutes of day: estimate, then remainder.
    p1_nxt   = 29'(sod) * 29'(RECIP60);
    m0_w     = p1_r[28:17];
    min2_nxt = 11'(m0_w);
    s2_nxt   = 7'(sod1_r - 17'(m0_w) * 17'(SECS_MIN));
    // Correct the minute estimate by one where needed.
    if (s2_r >= 7'(SECS_MIN)) begin
      min3_nxt = min2_r + 11'd1;
      sec3_nxt = 6'(s2_r - 7'(SECS_MIN));
    end else begin
      min3_nxt = min2_r;
      sec3_nxt = 6'(s2_r);
    end
    // Hours: same scheme on the minute count.
    p4_nxt  = 23'(min3_r) * 23'(RECIP60);
    h0_w    = p4_r[22:17];
    hr5_nxt = 5'(h0_w);
    mi5_nxt = 7'(min4_r - 11'(h0_w) * 11'(SECS_MIN));
    tm6_nxt.sod    = sod5_r;
    tm6_nxt.second = sec5_r;
    if (mi5_r >= 7'(SECS_MIN)) begin
      tm6_nxt.hour   = hr5_r + 5'd1;
      tm6_nxt.minute = 6'(mi5_r - 7'(SECS_MIN));
    end else begin
      tm6_nxt.hour   = hr5_r;
      tm6_nxt.minute = 6'(mi5_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r   <= p1_nxt;
      sod1_r <= sod;
      min2_r <= min2_nxt;
      s2_r   <= s2_nxt;
      sod2_r <= sod1_r;
      min3_r <= min3_nxt;
      sec3_r <= sec3_nxt;
      sod3_r <= sod2_r;
      p4_r   <= p4_nxt;
      min4_r <= min3_r;
      sec4_r <= sec3_r;
      sod4_r <= sod3_r;
      hr5_r  <= hr5_nxt;
      mi5_r  <= mi5_nxt;
      sec5_r <= sec4_r;
      sod5_r <= sod4_r;
      tm6_r  <= tm6_nxt;
      // Delay line that lines the time up with the date.
      pad_r[0] <= tm6_r;
      for (int i = 1; i < TIME_PAD; i++) begin
        pad_r[i] <= pad_r[i-1];
      end
    end
  end

  assign tm = pad_r[TIME_PAD-1];

endmodule

// ===== design/tscd_date.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscd_date
// Turns a day count since 1970-01-01 into year, month and day by peeling off
// 400, 100, 4 and 1 year cycles, then inverting the month table.
// ----------------------------------------------------------------------------
module tscd_date (
  input  logic                        clk,
  input  logic                        adv,
  input  logic [tscd_pkg::DAYS_W-1:0] days,
  input  logic                        oor,
  output tscd_pkg::tscd_date_t        dt
);
  import tscd_pkg::*;

  logic [DAYS_W-1:0] n1_nxt, n1_r, n2_r;
  logic [26:0]       p2_nxt, p2_r;
  logic [4:0]        q0_w, q3_r;
  logic [18:0]       r3_nxt, r3_r;
  logic [4:0]        q400_4_nxt, q400_4_r, q400_5_r, q400_6_r, q400_7_r, q400_8_r;
  logic [17:0]       r400_4_nxt, r400_4_r;
  logic [1:0]        q100_5_nxt, q100_5_r, q100_6_r, q100_7_r, q100_8_r;
  logic [15:0]       r100_5_nxt, r100_5_r, r100_6_r;
  logic [21:0]       p6_nxt, p6_r;
  logic [5:0]        q4a_w, q4a7_r;
  logic [11:0]       r7_nxt, r7_r;
  logic [4:0]        q4_8_nxt, q4_8_r;
  logic [10:0]       r4_8_nxt, r4_8_r;
  logic [1:0]        q1_w;
  logic [8:0]        r1_9_nxt, r1_9_r, r1_10_r;
  logic [YEAR_W-1:0] year9_nxt, year9_r, year10_r;
  logic              leap9_nxt, leap9_r, leap10_r;
  logic [MONTH_W-1:0] month10_nxt, month10_r;
  logic [9:0]        oor_r;
  tscd_date_t        dt11_nxt, dt11_r;

  always_comb begin
    // Day count since 0001-01-01.
    n1_nxt = days + 22'(DAYS_0001_TO_1970);
    // 400 year cycles: reciprocal estimate, remainder, correction.
    p2_nxt = 27'(n1_r) * 27'(RECIP400);
    q0_w   = p2_r[26:22];
    r3_nxt = 19'(n2_r - 22'(q0_w) * 22'(DAYS_400Y));
    if (r3_r >= 19'(DAYS_400Y)) begin
      q400_4_nxt = q3_r + 5'd1;
      r400_4_nxt = 18'(r3_r - 19'(DAYS_400Y));
    end else begin
      q400_4_nxt = q3_r;
      r400_4_nxt = 18'(r3_r);
    end
    // 100 year cycles: at most three, so the last day of a 400 year cycle
    // stays in the fourth century.
    q100_5_nxt = 2'(r400_4_r >= 18'(DAYS_100Y)) + 2'(r400_4_r >= 18'(2 * DAYS_100Y))
               + 2'(r400_4_r >= 18'(3 * DAYS_100Y));
    r100_5_nxt = 16'(r400_4_r - 18'(q100_5_nxt) * 18'(DAYS_100Y));
    // 4 year cycles.
    p6_nxt = 22'(r100_5_r) * 22'(RECIP1461);
    q4a_w  = p6_r[21:16];
    r7_nxt = 12'(r100_6_r - 16'(q4a_w) * 16'(DAYS_4Y));
    if (r7_r >= 12'(DAYS_4Y)) begin
      q4_8_nxt = 5'(q4a7_r + 6'd1);
      r4_8_nxt = 11'(r7_r - 12'(DAYS_4Y));
    end else begin
      q4_8_nxt = 5'(q4a7_r);
      r4_8_nxt = 11'(r7_r);
    end
    // Single years, clamped at three so that 31 December of a leap year
    // stays in that year; then the year number and its leap flag.
    q1_w = 2'(r4_8_r >= 11'(DAYS_1Y)) + 2'(r4_8_r >= 11'(2 * DAYS_1Y))
         + 2'(r4_8_r >= 11'(3 * DAYS_1Y));
    r1_9_nxt  = 9'(r4_8_r - 11'(q1_w) * 11'(DAYS_1Y));
    year9_nxt = 14'(q400_8_r) * 14'd400 + 14'(q100_8_r) * 14'd100
              + 14'(q4_8_r) * 14'd4 + 14'(q1_w) + 14'd1;
    leap9_nxt = (q1_w == 2'd3) && ((q4_8_r != 5'd24) || (q100_8_r == 2'd3));
    // Month: count month starts at or before the day of year.
    month10_nxt = 4'd1;
    for (int m = 2; m <= 12; m++) begin
      if (tscd_dbm(4'(m), leap9_r) <= r1_9_r) begin
        month10_nxt = month10_nxt + 4'd1;
      end
    end
    // Day of month, with the date zeroed beyond the supported range.
    dt11_nxt.oor = oor_r[9];
    if (oor_r[9]) begin
      dt11_nxt.year  = '0;
      dt11_nxt.month = '0;
      dt11_nxt.day   = '0;
    end else begin
      dt11_nxt.year  = year10_r;
      dt11_nxt.month = month10_r;
      dt11_nxt.day   = 5'(r1_10_r - tscd_dbm(month10_r, leap10_r) + 9'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oor_r     <= {oor_r[8:0], oor};
      n1_r      <= n1_nxt;
      p2_r      <= p2_nxt;
      n2_r      <= n1_r;
      q3_r      <= q0_w;
      r3_r      <= r3_nxt;
      q400_4_r  <= q400_4_nxt;
      r400_4_r  <= r400_4_nxt;
      q400_5_r  <= q400_4_r;
      q100_5_r  <= q100_5_nxt;
      r100_5_r  <= r100_5_nxt;
      p6_r      <= p6_nxt;
      r100_6_r  <= r100_5_r;
      q400_6_r  <= q400_5_r;
      q100_6_r  <= q100_5_r;
      q4a7_r    <= q4a_w;
      r7_r      <= r7_nxt;
      q400_7_r  <= q400_6_r;
      q100_7_r  <= q100_6_r;
      q4_8_r    <= q4_8_nxt;
      r4_8_r    <= r4_8_nxt;
      q400_8_r  <= q400_7_r;
      q100_8_r  <= q100_7_r;
      r1_9_r    <= r1_9_nxt;
      year9_r   <= year9_nxt;
      leap9_r   <= leap9_nxt;
      month10_r <= month10_nxt;
      r1_10_r   <= r1_9_r;
      year10_r  <= year9_r;
      leap10_r  <= leap9_r;
      dt11_r    <= dt11_nxt;
    end
  end

  assign dt = dt11_r;

endmodule

// ===== design/timestamp_to_calendar_date.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_to_calendar_date
// Converts a Unix timestamp in seconds into Gregorian date and time of day.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; every stage is a register of a single
// pipeline that advances whenever the output register is free or taken.
// A stalled output holds the whole pipeline, so nothing is lost or repeated.
// Reset clears the valid bits only; data registers are not reset.
module timestamp_to_calendar_date (
  input  logic        clk,
  input  logic        rst_n,
  tscd_in_if.sink     in_ch,
  tscd_out_if.source  out_ch
);
  import tscd_pkg::*;

  logic                  adv;
  logic [PIPE_DEPTH-1:0] vld_r;

  logic [T_W-1:0]       t1_r, t2_r;
  logic [DAY_LOW_W-1:0] lo1_r, lo2_r, lo3_r;
  logic                 oor1_nxt, oor1_r, oor2_r, oor3_r, oor4_r;
  logic [52:0]          prod2_nxt, prod2_r;
  logic [DAYS_W-1:0]    qd0_w, qd3_r;
  logic [10:0]          rem3_nxt, rem3_r;
  logic [DAYS_W-1:0]    days4_nxt, days4_r;
  logic [9:0]           rday_w;
  logic [SOD_W-1:0]     sod4_nxt, sod4_r;

  tscd_time_t tm;
  tscd_date_t dt;

  // The pipeline moves when the output register is empty or being taken.
  assign adv         = out_ch.ready || !vld_r[PIPE_DEPTH-1];
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_ch.valid};
    end
  end

  // Day split: seconds / 86400 as (seconds >> 7) / 675.
  always_comb begin
    oor1_nxt  = in_ch.unix_seconds > LAST_SECOND;
    prod2_nxt = 53'(t1_r) * 53'(RECIP675);
    qd0_w     = prod2_r[52:31];
    rem3_nxt  = 11'(t2_r - 31'(qd0_w) * 31'(DAY_ODD));
    if (rem3_r >= 11'(DAY_ODD)) begin
      days4_nxt = qd3_r + 22'd1;
      rday_w    = 10'(rem3_r - 11'(DAY_ODD));
    end else begin
      days4_nxt = qd3_r;
      rday_w    = 10'(rem3_r);
    end
    sod4_nxt = {rday_w, lo3_r};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_r    <= in_ch.unix_seconds[SECS_W-1:DAY_LOW_W];
      lo1_r   <= in_ch.unix_seconds[DAY_LOW_W-1:0];
      oor1_r  <= oor1_nxt;
      prod2_r <= prod2_nxt;
      t2_r    <= t1_r;
      lo2_r   <= lo1_r;
      oor2_r  <= oor1_r;
      qd3_r   <= qd0_w;
      rem3_r  <= rem3_nxt;
      lo3_r   <= lo2_r;
      oor3_r  <= oor2_r;
      days4_r <= days4_nxt;
      sod4_r  <= sod4_nxt;
      oor4_r  <= oor3_r;
    end
  end

  // Time of day and calendar date run side by side with equal latency.
  tscd_time u_time (
    .clk (clk),
    .adv (adv),
    .sod (sod4_r),
    .tm  (tm)
  );

  tscd_date u_date (
    .clk  (clk),
    .adv  (adv),
    .days (days4_r),
    .oor  (oor4_r),
    .dt   (dt)
  );

  // Result item.
  assign out_ch.valid         = vld_r[PIPE_DEPTH-1];
  assign out_ch.year          = dt.year;
  assign out_ch.month         = dt.month;
  assign out_ch.day_of_month  = dt.day;
  assign out_ch.out_of_range  = dt.oor;
  assign out_ch.hour          = tm.hour;
  assign out_ch.minute        = tm.minute;
  assign out_ch.second        = tm.second;
  assign out_ch.second_of_day = tm.sod;

endmodule

// ===== dv/timestamp_to_calendar_date_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_to_calendar_date_test
// Self-checking bench for the timestamp to calendar date converter. Each
// accepted timestamp is converted in the bench by an independent calendar
// calculation, and each result item is compared field by field, in order,
// with the oldest pending date. Directed calendar edges come first, then
// random timestamps under random idling on both channels, a long output
// stall, and finally a stretch at full rate.
// ----------------------------------------------------------------------------
module timestamp_to_calendar_date_test;
  import tscd_pkg::*;

  localparam int unsigned RESET_CYCLES     = 9;
  localparam int unsigned WATCHDOG_LIMIT   = 5000;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned MAX_REPORTS      = 60;

  localparam longint unsigned SECS_PER_DAY     = 86400;
  localparam longint unsigned LAST_TS          = LAST_SECOND;
  localparam longint unsigned MAX_TS           = (64'd1 << SECS_W) - 1;
  localparam int unsigned     LAST_DAY_INDEX   = 2932896;
  localparam int unsigned     MONTH_DAYS [12]  = '{31, 28, 31, 30, 31, 30,
                                                   31, 31, 30, 31, 30, 31};

  // One expected result, with the timestamp that caused it.
  typedef struct packed {
    logic [SECS_W-1:0]  unix_seconds;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day_of_month;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic [SOD_W-1:0]   second_of_day;
    logic               out_of_range;
  } calendar_t;

  logic clk;
  logic rst_n;

  tscd_in_if  in_bus ();
  tscd_out_if out_bus ();

  calendar_t   pending_dates [$];
  int unsigned error_count;
  int unsigned quiet_cycles;
  bit          src_idle_on;
  bit          sink_idle_on;
  bit          hold_request;

  timestamp_to_calendar_date u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // Clock.
  always #1 clk = ~clk;

  // Independent conversion of a timestamp into date and time of day.
  function automatic calendar_t predict_calendar(input logic [SECS_W-1:0] ts);
    calendar_t       c;
    longint unsigned secs;
    int unsigned     sod;
    int unsigned     day_num;
    int unsigned     rem;
    int unsigned     q400;
    int unsigned     q100;
    int unsigned     q4;
    int unsigned     q1;
    int unsigned     yr;
    int unsigned     mo;
    int unsigned     mlen;
    bit              leap;
    c = '0;
    secs = ts;
    sod = int'(secs % SECS_PER_DAY);
    c.unix_seconds  = ts;
    c.hour          = HOUR_W'(sod / 3600);
    c.minute        = MIN_W'((sod / 60) % 60);
    c.second        = SEC_W'(sod % 60);
    c.second_of_day = SOD_W'(sod);
    c.out_of_range  = (secs > LAST_TS);
    if (!c.out_of_range) begin
      // Day number counted from 0001-01-01, split by the Gregorian cycles.
      day_num = int'(secs / SECS_PER_DAY) + DAYS_0001_TO_1970;
      q400 = day_num / DAYS_400Y;
      rem  = day_num % DAYS_400Y;
      q100 = rem / DAYS_100Y;
      if (q100 > 3) q100 = 3;
      rem  = rem - q100 * DAYS_100Y;
      q4   = rem / DAYS_4Y;
      rem  = rem - q4 * DAYS_4Y;
      q1   = rem / DAYS_1Y;
      if (q1 > 3) q1 = 3;
      rem  = rem - q1 * DAYS_1Y;
      yr   = 400 * q400 + 100 * q100 + 4 * q4 + q1 + 1;
      leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
      // Walk the months until the day of year falls inside one.
      mo   = 1;
      mlen = MONTH_DAYS[0];
      while (rem >= mlen) begin
        rem  = rem - mlen;
        mo   = mo + 1;
        mlen = MONTH_DAYS[mo-1] + ((mo == 2 && leap) ? 1 : 0);
      end
      c.year         = YEAR_W'(yr);
      c.month        = MONTH_W'(mo);
      c.day_of_month = DAY_W'(rem + 1);
    end
    return c;
  endfunction

  // Compares one field of a result item with its expectation.
  task automatic check_field(input string field, input longint unsigned want,
                             input longint unsigned got,
                             input logic [SECS_W-1:0] ts);
    if (want != got) begin
      error_count++;
      if (error_count <= MAX_REPORTS) begin
        $display("%0t: %s mismatch for timestamp %0d: expected %0d, actual %0d",
                 $time, field, ts, want, got);
      end
    end
  endtask

  // Sends one timestamp; called and returning at a falling edge with valid
  // still high, so back-to-back items keep valid up.
  task automatic send_timestamp(input longint unsigned ts);
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.unix_seconds <= SECS_W'(ts);
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    pending_dates.push_back(predict_calendar(SECS_W'(ts)));
    @(negedge clk);
  endtask

  // Random timestamp: mostly in range, some on day boundaries, some beyond 9999.
  function automatic longint unsigned random_timestamp();
    longint unsigned raw;
    longint unsigned day;
    int unsigned     pick;
    raw  = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      return raw % (LAST_TS + 1);
    end else if (pick < 85) begin
      day = $urandom_range(0, LAST_DAY_INDEX);
      case ($urandom_range(0, 2))
        0:       return day * SECS_PER_DAY;
        1:       return day * SECS_PER_DAY + SECS_PER_DAY - 1;
        default: return day * SECS_PER_DAY + $urandom_range(0, 86399);
      endcase
    end else begin
      return LAST_TS + 1 + raw % (MAX_TS - LAST_TS);
    end
  endfunction

  // Calendar edges: epoch, time-of-day extremes, leap days, century rules,
  // the last supported second and the out-of-range region.
  task automatic test_calendar_edges();
    longint unsigned edges [$];
    edges = '{0, 1, 59, 60, 3599, 3600, 86399, 86400,
              68169600,        // 1972-02-29
              94608000,        // 1972-12-31
              951782400,       // 2000-02-29
              978307199,       // 2000-12-31 23:59:59
              4107542399,      // 2100-02-28 23:59:59
              4107542400,      // 2100-03-01
              LAST_TS - 86399, LAST_TS, LAST_TS + 1, LAST_TS + 86400,
              64'd1 << (SECS_W - 1), MAX_TS - 1, MAX_TS};
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    foreach (edges[i]) send_timestamp(edges[i]);
  endtask

  // Random timestamps with idling switched on and off per stretch.
  task automatic test_random_dates();
    for (int i = 0; i < 1500; i++) begin
      if (i % 100 == 0) begin
        src_idle_on  = ($urandom_range(0, 2) != 0);
        sink_idle_on = ($urandom_range(0, 2) != 0);
      end
      send_timestamp(random_timestamp());
    end
  endtask

  // The receiver holds off for a long stretch while items keep coming, so
  // the pipeline fills and the input stalls.
  task automatic test_output_backpressure();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < 100; i++) send_timestamp(random_timestamp());
  endtask

  // Last part: both sides at full rate.
  task automatic test_full_rate();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    for (int i = 0; i < 350; i++) send_timestamp(random_timestamp());
  endtask

  // Receiver: random stalls, or a long hold when one is requested.
  initial begin : result_ready
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_bus.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Result checker: each accepted result against the oldest pending date.
  always @(posedge clk) begin
    calendar_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_dates.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: expected none, actual year %0d month %0d day %0d",
                 $time, out_bus.year, out_bus.month, out_bus.day_of_month);
      end else begin
        want = pending_dates.pop_front();
        check_field("year", want.year, out_bus.year, want.unix_seconds);
        check_field("month", want.month, out_bus.month, want.unix_seconds);
        check_field("day_of_month", want.day_of_month, out_bus.day_of_month,
                    want.unix_seconds);
        check_field("hour", want.hour, out_bus.hour, want.unix_seconds);
        check_field("minute", want.minute, out_bus.minute, want.unix_seconds);
        check_field("second", want.second, out_bus.second, want.unix_seconds);
        check_field("second_of_day", want.second_of_day, out_bus.second_of_day,
                    want.unix_seconds);
        check_field("out_of_range", want.out_of_range, out_bus.out_of_range,
                    want.unix_seconds);
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any accepted item.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Sequence of tests.
  initial begin : main_sequence
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.unix_seconds = '0;
    out_bus.ready       = 1'b0;
    error_count         = 0;
    quiet_cycles        = 0;
    src_idle_on         = 1'b0;
    sink_idle_on        = 1'b0;
    hold_request        = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_calendar_edges();
    test_random_dates();
    test_output_backpressure();
    test_full_rate();
    in_bus.valid <= 1'b0;

    // Drain, then watch a little longer for stray results.
    wait (pending_dates.size() == 0);
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
